[rtl/hpq_pkg.sv]
// Package for the binary max-heap priority queue.
// Holds the sizing constants, operation and status codes, and the structs
// shared by the sequencer, the compare unit and the top level.
`default_nettype none

package hpq_pkg;

  // Number of keys the heap can hold.
  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  // Operation codes on the input channel.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // Status codes on the result channel.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // One cycle's access to the key store: one write and one read.
  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic signed [KEY_W-1:0]  wdata;
    logic                     re;
    logic [ADDR_W-1:0]        raddr;
  } mem_req_t;

  // Operands of the shared compare unit.
  typedef struct packed {
    logic signed [KEY_W-1:0] a;
    logic signed [KEY_W-1:0] b;
  } cmp_req_t;

  // Result of the shared compare unit.
  typedef struct packed {
    logic                    gt;
    logic signed [KEY_W-1:0] max;
  } cmp_res_t;

endpackage

`default_nettype wire

[rtl/hpq_if.sv]
// Valid/ready channel interfaces for the heap queue: commands in, results out.
// Depends on hpq_pkg for field widths.
`default_nettype none

interface hpq_in_if;
  import hpq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    func;
  logic signed [KEY_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface hpq_out_if;
  import hpq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] removed_value;
  logic [STATUS_W-1:0]     status;
  logic [COUNT_W-1:0]      entry_count;

  modport source (output valid, output removed_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input removed_value, input status, input entry_count,
                  output ready);
endinterface

`default_nettype wire

[rtl/max_heap_priority_queue.sv]
// Top level of the binary max-heap priority queue.
// Depends on hpq_pkg, hpq_if, hpq_ram, hpq_cmp and hpq_seq.
//
// Usage: commands arrive as beats on in_ch (func, value) and every command
// returns exactly one beat on out_ch (removed_value, status, entry_count).
// An insert (func 0) adds a signed key; a remove (func 1) returns the largest
// key. A remove on an empty heap reports an empty status with a zero value;
// an insert into a full heap drops the key and reports a full status. In
// both of those cases the stored keys and the count do not change.
// One command is worked on at a time, and in_ch.ready is low while it runs.
// Each tree level costs key store reads and a compare: an insert reads the
// parent at each level it climbs, and a remove reads the children at each
// level it descends, through the single read port. Full and empty commands
// go straight to the result without touching the key store. The tree depth,
// log2 of the capacity, bounds how many levels a command walks.
// The result sits in an output register; the next command is accepted while
// it waits. If the receiver stalls, the following command finishes its work
// and then waits until the held beat is taken.
// Reset (rst_n low, synchronous) empties the heap at once; the key store
// itself is not cleared, since only entries below the count are ever read.
`default_nettype none

module max_heap_priority_queue (
  input  wire logic clk,
  input  wire logic rst_n,
  hpq_in_if.sink    in_ch,
  hpq_out_if.source out_ch
);
  import hpq_pkg::*;

  mem_req_t                mem_req;
  logic signed [KEY_W-1:0] mem_rdata;
  cmp_req_t                cmp_req;
  cmp_res_t                cmp_res;

  // Sequencer: owns the count, the walking position and the result register.
  hpq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .cmp_req   (cmp_req),
    .cmp_res   (cmp_res)
  );

  // The heap's key store, laid out as an implicit binary tree.
  hpq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // One signed compare, reused at every level of both sift directions.
  hpq_cmp u_cmp (
    .req (cmp_req),
    .res (cmp_res)
  );

endmodule

`default_nettype wire

[rtl/hpq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used as the heap key store.
`default_nettype none

module hpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/hpq_cmp.sv]
// Shared signed key compare unit: flags a > b and passes on the larger key.
// Depends on hpq_pkg for the operand and result structs.
`default_nettype none

module hpq_cmp (
  input  wire hpq_pkg::cmp_req_t req,
  output hpq_pkg::cmp_res_t      res
);
  import hpq_pkg::*;

  always_comb begin
    res.gt  = (req.a > req.b);
    res.max = res.gt ? req.a : req.b;
  end

endmodule

`default_nettype wire

[rtl/hpq_seq.sv]
// Sequencer of the heap queue: walks sift-up and sift-down one level at a time
// through the key store and the shared compare unit, and holds the result beat.
// Depends on hpq_pkg and the channel interfaces in hpq_if.
`default_nettype none

module hpq_seq (
  input  wire logic         clk,
  input  wire logic         rst_n,
  hpq_in_if.sink            in_ch,
  hpq_out_if.source         out_ch,
  output hpq_pkg::mem_req_t mem_req,
  input  wire logic signed [hpq_pkg::KEY_W-1:0] mem_rdata,
  output hpq_pkg::cmp_req_t cmp_req,
  input  wire hpq_pkg::cmp_res_t cmp_res
);
  import hpq_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_UP_RD     = 4'd1;
  localparam logic [3:0] S_UP_CMP    = 4'd2;
  localparam logic [3:0] S_RM_ROOT   = 4'd3;
  localparam logic [3:0] S_RM_LAST   = 4'd4;
  localparam logic [3:0] S_RM_LOAD   = 4'd5;
  localparam logic [3:0] S_DN_RD_L   = 4'd6;
  localparam logic [3:0] S_DN_RD_R   = 4'd7;
  localparam logic [3:0] S_DN_CMP    = 4'd8;
  localparam logic [3:0] S_DONE      = 4'd9;

  localparam int IDX_W = ADDR_W + 2;

  logic [3:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [ADDR_W-1:0]       pos_r, pos_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [KEY_W-1:0] best_r, best_nxt;
  logic                    best_left_r, best_left_nxt;
  logic signed [KEY_W-1:0] removed_r, removed_nxt;
  logic [STATUS_W-1:0]     status_r, status_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [KEY_W-1:0] out_removed_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic [COUNT_W-1:0]      out_count_r;
  logic                    out_load;

  logic [ADDR_W-1:0] parent;
  logic [IDX_W-1:0]  left_idx, right_idx, cnt_ext;
  logic              left_in, right_in, full;
  logic [ADDR_W-1:0] left_addr, right_addr;

  // The key being placed is held aside (a hole walks through the tree), so
  // each level costs one write instead of a full swap.
  always_comb begin
    parent     = (pos_r - ADDR_W'(1)) >> 1;
    left_idx   = {1'b0, pos_r, 1'b1};
    right_idx  = left_idx + IDX_W'(1);
    cnt_ext    = IDX_W'(count_r);
    left_in    = (left_idx < cnt_ext);
    right_in   = (right_idx < cnt_ext);
    left_addr  = left_idx[ADDR_W-1:0];
    right_addr = right_idx[ADDR_W-1:0];
    full       = (count_r >= CNT_W'(CAPACITY));
  end

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    cmp_req.a = mem_rdata;
    cmp_req.b = key_r;
    if (state_r == S_UP_CMP) begin
      cmp_req.a = key_r;
      cmp_req.b = mem_rdata;
    end else if (state_r == S_DN_CMP) begin
      cmp_req.b = best_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    best_nxt      = best_r;
    best_left_nxt = best_left_r;
    removed_nxt   = removed_r;
    status_nxt    = status_r;
    out_load      = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = pos_r;
    mem_req.wdata = key_r;
    mem_req.re    = 1'b0;
    mem_req.raddr = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          key_nxt     = in_ch.value;
          removed_nxt = '0;
          status_nxt  = ST_OK;
          if (in_ch.func == FUNC_INSERT) begin
            if (full) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              pos_nxt   = count_r[ADDR_W-1:0];
              count_nxt = count_r + CNT_W'(1);
              state_nxt = S_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              count_nxt = count_r - CNT_W'(1);
              state_nxt = S_RM_ROOT;
            end
          end
        end
      end
      S_UP_RD: begin
        if (pos_r == '0) begin
          mem_req.we = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = parent;
          state_nxt     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_req.we = 1'b1;
        if (cmp_res.gt) begin
          mem_req.wdata = mem_rdata;
          pos_nxt       = parent;
          state_nxt     = S_UP_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RM_ROOT: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = '0;
        state_nxt     = S_RM_LAST;
      end
      S_RM_LAST: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = count_r[ADDR_W-1:0];
        removed_nxt   = mem_rdata;
        state_nxt     = S_RM_LOAD;
      end
      S_RM_LOAD: begin
        key_nxt = mem_rdata;
        pos_nxt = '0;
        if (count_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DN_RD_L;
        end
      end
      S_DN_RD_L: begin
        if (left_in) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = left_addr;
          state_nxt     = S_DN_RD_R;
        end else begin
          mem_req.we = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DN_RD_R: begin
        best_nxt      = cmp_res.max;
        best_left_nxt = cmp_res.gt;
        if (right_in) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = right_addr;
          state_nxt     = S_DN_CMP;
        end else begin
          mem_req.we = 1'b1;
          if (cmp_res.gt) begin
            mem_req.wdata = mem_rdata;
            pos_nxt       = left_addr;
            state_nxt     = S_DN_RD_L;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DN_CMP: begin
        mem_req.we = 1'b1;
        if (cmp_res.gt) begin
          mem_req.wdata = mem_rdata;
          pos_nxt       = right_addr;
          state_nxt     = S_DN_RD_L;
        end else if (best_left_r) begin
          mem_req.wdata = best_r;
          pos_nxt       = left_addr;
          state_nxt     = S_DN_RD_L;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    key_r       <= key_nxt;
    best_r      <= best_nxt;
    best_left_r <= best_left_nxt;
    removed_r   <= removed_nxt;
    status_r    <= status_nxt;
    if (out_load) begin
      out_removed_r <= removed_r;
      out_status_r  <= status_r;
      out_count_r   <= COUNT_W'(count_r);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.removed_value = out_removed_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.entry_count   = out_count_r;

endmodule

`default_nettype wire

[rtl/hpq_chk.sv]
// Port-level checker for the heap queue, attached to the top level by bind.
// Depends on hpq_pkg for widths and status codes.
`default_nettype none

module hpq_chk (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [hpq_pkg::KEY_W-1:0]        out_removed_value,
  input wire logic [hpq_pkg::STATUS_W-1:0]     out_status,
  input wire logic [hpq_pkg::COUNT_W-1:0]      out_entry_count
);
  import hpq_pkg::*;

  // A waiting result beat holds its contents until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_removed_value)
      && $stable(out_status) && $stable(out_entry_count))
    else $error("result beat changed while stalled");

  // One command at a time: the block is busy right after taking one.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted while another is in progress");

  // An empty report leaves nothing in the heap and returns no key.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_entry_count == '0
      && out_removed_value == '0)
    else $error("empty status with keys held or a key returned");

  // A full report means the heap holds its whole capacity.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_count == COUNT_W'(CAPACITY)
      && out_removed_value == '0)
    else $error("full status below capacity");

endmodule

bind max_heap_priority_queue hpq_chk u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_removed_value (out_ch.removed_value),
  .out_status        (out_ch.status),
  .out_entry_count   (out_ch.entry_count)
);

`default_nettype wire

[bench/tb.sv]
// Self-checking bench for max_heap_priority_queue: directed and random commands, with a
// heap model that predicts the results not typed in by hand. Depends on hpq_pkg and the interfaces in hpq_if.
`default_nettype none

module tb;
  import hpq_pkg::*;

  // One result beat as the block returns it.
  typedef struct packed {
    logic signed [KEY_W-1:0] removed_value;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_W-1:0]      entry_count;
  } heap_result_t;

  // A directed command. Rows with known set carry the result typed in by hand.
  // The other rows are checked against the heap model.
  typedef struct {
    logic                    func;
    logic signed [KEY_W-1:0] value;
    bit                      known;
    heap_result_t            want;
  } cmd_row_t;

  // Cycles without any accepted beat before the run is declared hung.
  // The slowest correct gap adds an input gap, a remove and a receiver stall.
  localparam int HANG_LIMIT = 1000;
  localparam int N_DIRECTED = 25;

  logic clk = 1'b0;
  logic rst_n;

  hpq_in_if  in_ch ();
  hpq_out_if out_ch ();

  max_heap_priority_queue DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // Heap model: keys in an implicit binary tree, children of k at 2k+1 and 2k+2.
  logic signed [KEY_W-1:0] heap_keys [CAPACITY];
  int                      heap_fill = 0;

  // Results predicted for accepted commands and not yet returned, oldest first.
  heap_result_t pending_results [$];

  int  error_count = 0;
  int  idle_cycles = 0;
  bit  in_quiet    = 1'b0;
  bit  out_quiet   = 1'b0;
  int  stall_left  = 0;

  // The directed part. The first rows walk through the extreme keys, equal keys,
  // removal down to the last entry and removal from an empty heap. The tail
  // builds a small heap with ties and leaves the removal order to the model.
  cmd_row_t directed_rows [N_DIRECTED] = '{
    '{FUNC_REMOVE, 32'sd0,           1'b1, '{32'sd0,           ST_EMPTY, 9'd0}},
    '{FUNC_INSERT, 32'sh7FFFFFFF,    1'b1, '{32'sd0,           ST_OK,    9'd1}},
    '{FUNC_INSERT, 32'sh80000000,    1'b1, '{32'sd0,           ST_OK,    9'd2}},
    '{FUNC_INSERT, 32'sd0,           1'b1, '{32'sd0,           ST_OK,    9'd3}},
    '{FUNC_INSERT, -32'sd1,          1'b1, '{32'sd0,           ST_OK,    9'd4}},
    '{FUNC_INSERT, 32'sd5,           1'b1, '{32'sd0,           ST_OK,    9'd5}},
    '{FUNC_INSERT, 32'sd5,           1'b1, '{32'sd0,           ST_OK,    9'd6}},
    '{FUNC_REMOVE, 32'shFFFFFFFF,    1'b1, '{32'sh7FFFFFFF,    ST_OK,    9'd5}},
    '{FUNC_REMOVE, 32'sd0,           1'b1, '{32'sd5,           ST_OK,    9'd4}},
    '{FUNC_REMOVE, 32'sd0,           1'b1, '{32'sd5,           ST_OK,    9'd3}},
    '{FUNC_REMOVE, 32'sd0,           1'b1, '{32'sd0,           ST_OK,    9'd2}},
    '{FUNC_REMOVE, 32'sd0,           1'b1, '{-32'sd1,          ST_OK,    9'd1}},
    '{FUNC_REMOVE, 32'sd0,           1'b1, '{32'sh80000000,    ST_OK,    9'd0}},
    '{FUNC_REMOVE, 32'sh5A5AA5A5,    1'b1, '{32'sd0,           ST_EMPTY, 9'd0}},
    '{FUNC_INSERT, 32'sd3,           1'b1, '{32'sd0,           ST_OK,    9'd1}},
    '{FUNC_INSERT, 32'sd7,           1'b1, '{32'sd0,           ST_OK,    9'd2}},
    '{FUNC_INSERT, 32'sd7,           1'b0, '{32'sd0,           ST_OK,    9'd0}},
    '{FUNC_INSERT, 32'sd7,           1'b0, '{32'sd0,           ST_OK,    9'd0}},
    '{FUNC_INSERT, 32'sd3,           1'b0, '{32'sd0,           ST_OK,    9'd0}},
    '{FUNC_INSERT, 32'shAAAAAAAA,    1'b0, '{32'sd0,           ST_OK,    9'd0}},
    '{FUNC_REMOVE, 32'sd0,           1'b0, '{32'sd0,           ST_OK,    9'd0}},
    '{FUNC_REMOVE, 32'sd0,           1'b0, '{32'sd0,           ST_OK,    9'd0}},
    '{FUNC_REMOVE, 32'sd0,           1'b0, '{32'sd0,           ST_OK,    9'd0}},
    '{FUNC_INSERT, 32'sh55555555,    1'b0, '{32'sd0,           ST_OK,    9'd0}},
    '{FUNC_REMOVE, 32'sd0,           1'b0, '{32'sd0,           ST_OK,    9'd0}}
  };

  // Applies one command to the heap model and returns the beat it should produce.
  // Sifting stops on equal keys, and the left child wins a tie on the way down.
  function automatic heap_result_t heap_apply(input logic func,
                                              input logic signed [KEY_W-1:0] value);
    heap_result_t            res;
    int                      pos;
    int                      up;
    int                      left;
    int                      right;
    int                      best;
    logic signed [KEY_W-1:0] tmp;
    res.removed_value = '0;
    res.status        = ST_OK;
    if (func == FUNC_INSERT) begin
      if (heap_fill >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        pos = heap_fill;
        heap_keys[pos] = value;
        heap_fill++;
        while (pos != 0) begin
          up = (pos - 1) / 2;
          if (!(heap_keys[pos] > heap_keys[up])) break;
          tmp = heap_keys[pos];
          heap_keys[pos] = heap_keys[up];
          heap_keys[up] = tmp;
          pos = up;
        end
      end
    end else begin
      if (heap_fill == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.removed_value = heap_keys[0];
        heap_fill--;
        if (heap_fill > 0) begin
          heap_keys[0] = heap_keys[heap_fill];
          pos = 0;
          forever begin
            left  = 2 * pos + 1;
            right = 2 * pos + 2;
            best  = pos;
            if (left < heap_fill && heap_keys[left] > heap_keys[best]) best = left;
            if (right < heap_fill && heap_keys[right] > heap_keys[best]) best = right;
            if (best == pos) break;
            tmp = heap_keys[pos];
            heap_keys[pos] = heap_keys[best];
            heap_keys[best] = tmp;
            pos = best;
          end
        end
      end
    end
    res.entry_count = COUNT_W'(heap_fill);
    return res;
  endfunction

  // Random key: the extremes, a narrow band that produces many ties, or any value.
  function automatic logic signed [KEY_W-1:0] draw_key();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(0, 9))
      0:       k = 32'sh7FFFFFFF;
      1:       k = 32'sh80000000;
      2, 3:    k = $signed(KEY_W'($urandom_range(0, 15))) - 32'sd8;
      default: k = $signed($urandom());
    endcase
    return k;
  endfunction

  // Sends one command beat after a random gap (none in a quiet stretch) and predicts its result once it is
  // accepted. Valid stays high between back-to-back beats, so it never gets two
  // assignments in one time step.
  task automatic issue_command(input logic func, input logic signed [KEY_W-1:0] value,
                               input bit known, input heap_result_t want);
    int           gap;
    heap_result_t predicted;
    gap = in_quiet ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= func;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    predicted = heap_apply(func, value);
    pending_results.insert(pending_results.size(), known ? want : predicted);
  endtask

  // A stretch of random commands; insert_pct steers the fill level up or down.
  task automatic run_mix(input int count, input int insert_pct);
    logic func;
    repeat (count) begin
      if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
      func = ($urandom_range(1, 100) <= insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
      issue_command(func, draw_key(), 1'b0, '0);
    end
  endtask

  // Receiver pacing. After each taken beat it draws a random stall, which may be none.
  // Now and then it switches to a stretch with no stalls at all.
  always @(posedge clk) begin : rx_pace
    int n;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (out_ch.ready) begin
      if (out_ch.valid) begin
        if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
        n = out_quiet ? 0 : $urandom_range(0, 19);
        if (n != 0) begin
          out_ch.ready <= 1'b0;
          stall_left   <= n - 1;
        end
      end
    end else if (stall_left == 0) begin
      out_ch.ready <= 1'b1;
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // Result checker: each taken beat is compared with the oldest prediction.
  always @(posedge clk) begin : result_check
    heap_result_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no command outstanding");
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_ch.removed_value !== exp_res.removed_value) begin
          $error("removed_value: expected %0d, actual %0d",
                 exp_res.removed_value, out_ch.removed_value);
          error_count++;
        end
        if (out_ch.status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, out_ch.status);
          error_count++;
        end
        if (out_ch.entry_count !== exp_res.entry_count) begin
          $error("entry_count: expected %0d, actual %0d",
                 exp_res.entry_count, out_ch.entry_count);
          error_count++;
        end
      end
    end
  end

  // Hang detector: counts cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.func   <= FUNC_INSERT;
    in_ch.value  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      issue_command(directed_rows[i].func, directed_rows[i].value,
                    directed_rows[i].known, directed_rows[i].want);

    // Random mix, then fill to capacity and push a few inserts into the full heap.
    run_mix(300, 60);
    while (heap_fill < CAPACITY) issue_command(FUNC_INSERT, draw_key(), 1'b0, '0);
    repeat (4) issue_command(FUNC_INSERT, draw_key(), 1'b0, '0);

    // An even mix near capacity keeps bouncing off the full limit.
    run_mix(250, 50);

    // Drain completely, then remove from the empty heap a few times.
    while (heap_fill > 0) issue_command(FUNC_REMOVE, draw_key(), 1'b0, '0);
    repeat (3) issue_command(FUNC_REMOVE, draw_key(), 1'b0, '0);

    run_mix(520, 55);

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Stray beats would show up here as results with no command outstanding.
    repeat (40) @(posedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/hpq_pkg.sv
rtl/hpq_if.sv
rtl/hpq_ram.sv
rtl/hpq_cmp.sv
rtl/hpq_seq.sv
rtl/max_heap_priority_queue.sv
rtl/hpq_chk.sv
bench/tb.sv
